>>> hdl/vc71_pkg.sv
// Shared types, constants and alphabet mapping functions for the 71-symbol Vigenere cipher.
package vc71_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned IdxW  = 7;

  localparam logic [IdxW-1:0] ALPHA_SIZE = 7'd71;
  localparam logic [IdxW-1:0] BAD_INDEX  = 7'd127;

  typedef enum logic {
    CMD_CIPHER = 1'b0,
    CMD_KEY    = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_DECRYPT = 1'b0,
    REG_KEY_LEN = 1'b1
  } reg_e;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             invalid;
  } result_t;

  function automatic logic [IdxW-1:0] sym_index(input logic [CharW-1:0] ch);
    logic [IdxW-1:0] idx;
    idx = BAD_INDEX;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      idx = 7'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      idx = 7'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      idx = 7'(ch - 8'h30 + 8'd52);
    end else begin
      case (ch)
        8'h21:   idx = 7'd62;
        8'h40:   idx = 7'd63;
        8'h23:   idx = 7'd64;
        8'h24:   idx = 7'd65;
        8'h25:   idx = 7'd66;
        8'h5e:   idx = 7'd67;
        8'h26:   idx = 7'd68;
        8'h2a:   idx = 7'd69;
        8'h20:   idx = 7'd70;
        default: idx = BAD_INDEX;
      endcase
    end
    return idx;
  endfunction

  function automatic logic [CharW-1:0] sym_char(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] ch;
    logic [CharW-1:0] ext;
    ext = {1'b0, idx};
    ch  = 8'h20;
    if (idx < 7'd26) begin
      ch = 8'h41 + ext;
    end else if (idx < 7'd52) begin
      ch = 8'h61 + ext - 8'd26;
    end else if (idx < 7'd62) begin
      ch = 8'h30 + ext - 8'd52;
    end else begin
      case (idx)
        7'd62:   ch = 8'h21;
        7'd63:   ch = 8'h40;
        7'd64:   ch = 8'h23;
        7'd65:   ch = 8'h24;
        7'd66:   ch = 8'h25;
        7'd67:   ch = 8'h5e;
        7'd68:   ch = 8'h26;
        7'd69:   ch = 8'h2a;
        default: ch = 8'h20;
      endcase
    end
    return ch;
  endfunction

endpackage

>>> hdl/vc71_cipher.sv
// Modular add or subtract of alphabet indexes and mapping back to a character.
module vc71_cipher import vc71_pkg::*; (
  input  logic             decrypt_i,
  input  logic [CharW-1:0] char_i,
  input  logic [IdxW-1:0]  msg_idx_i,
  input  logic [IdxW-1:0]  key_idx_i,
  output result_t          result_o
);

  logic [IdxW:0]   sum;
  logic [IdxW:0]   wrapped;
  logic            bad;

  assign bad = (msg_idx_i >= ALPHA_SIZE) || (key_idx_i >= ALPHA_SIZE);

  always_comb begin
    if (decrypt_i) begin
      sum = {1'b0, msg_idx_i} + {1'b0, ALPHA_SIZE} - {1'b0, key_idx_i};
    end else begin
      sum = {1'b0, msg_idx_i} + {1'b0, key_idx_i};
    end
    if (sum >= {1'b0, ALPHA_SIZE}) begin
      wrapped = sum - {1'b0, ALPHA_SIZE};
    end else begin
      wrapped = sum;
    end
  end

  assign result_o.char_out = bad ? char_i : sym_char(wrapped[IdxW-1:0]);
  assign result_o.invalid  = bad;

endmodule

>>> hdl/vigenere_cipher_71_symbol.sv
// Top level of the 71-symbol Vigenere cipher. The block takes one item per clock unless the
// output is stalled. For an accepted message item the key store (a synchronous memory of
// KEY_DEPTH entries) is read at the current key position and the message character is
// mapped to its alphabet index, both into registers; then the indexes are added or
// subtracted modulo 71 and the result moves into the output register once it can take it.
// Key write items update the key store in their accept cycle and give no result; a
// message item that follows reads the new entry. Configuration writes go through the APB
// port while the block is idle, which the user must ensure; the block does not enforce it.
module vigenere_cipher_71_symbol import vc71_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // char_in[7:0], key_slot[13:8], first_of_message[14]
  input  logic        s_axis_tuser_i,   // cmd[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // char_out[7:0]
  output logic        m_axis_tuser_o,   // invalid[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned LenW  = ($clog2(KEY_DEPTH + 1) > 7) ? $clog2(KEY_DEPTH + 1) : 7;
  localparam logic [LenW-1:0] DepthL = LenW'(KEY_DEPTH);

  logic            decrypt_q;
  logic [6:0]      key_len_q;
  logic [PW-1:0]   key_pos_q, key_pos_d;

  logic [IdxW-1:0] key_mem_q [KEY_DEPTH];
  logic [IdxW-1:0] key_rd_q;

  logic             s1_valid_q, s1_valid_d;
  logic [CharW-1:0] s1_char_q;
  logic [IdxW-1:0]  s1_idx_q;

  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  result_t          cipher_res;

  logic             in_acc, msg_acc, key_acc, key_we, s1_adv, cfg_we;
  logic [CharW-1:0] in_char;
  logic [5:0]       in_slot;
  logic             in_first;
  cmd_e             in_cmd;

  logic [LenW-1:0]  eff_len, len_ext, pos_ext, next_ext;
  logic [PW-1:0]    pos_sel;

  assign in_char  = s_axis_tdata_i[7:0];
  assign in_slot  = s_axis_tdata_i[13:8];
  assign in_first = s_axis_tdata_i[14];
  assign in_cmd   = cmd_e'(s_axis_tuser_i);

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign msg_acc         = in_acc && (in_cmd == CMD_CIPHER);
  assign key_acc         = in_acc && (in_cmd == CMD_KEY);
  assign key_we          = key_acc && (LenW'(in_slot) < DepthL);

  // Effective key length and position for this item
  always_comb begin
    len_ext = LenW'(key_len_q);
    priority if (len_ext == '0) begin
      eff_len = LenW'(1);
    end else if (len_ext > DepthL) begin
      eff_len = DepthL;
    end else begin
      eff_len = len_ext;
    end
    pos_ext = LenW'(key_pos_q);
    pos_sel = (in_first || pos_ext >= eff_len) ? '0 : key_pos_q;
    next_ext = LenW'(pos_sel) + LenW'(1);
    key_pos_d = key_pos_q;
    if (msg_acc) begin
      key_pos_d = (next_ext >= eff_len) ? '0 : PW'(next_ext);
    end
  end

  // Key store
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem_q[PW'(in_slot)] <= sym_index(in_char);
    end
    if (msg_acc) begin
      key_rd_q <= key_mem_q[pos_sel];
    end
  end

  always_ff @(posedge clk_i) begin
    if (msg_acc) begin
      s1_char_q <= in_char;
      s1_idx_q  <= sym_index(in_char);
    end
    if (s1_adv) begin
      out_q <= cipher_res;
    end
  end

  vc71_cipher u_cipher (
    .decrypt_i (decrypt_q),
    .char_i    (s1_char_q),
    .msg_idx_i (s1_idx_q),
    .key_idx_i (key_rd_q),
    .result_o  (cipher_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = msg_acc;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_DECRYPT: prdata = {31'd0, decrypt_q};
      REG_KEY_LEN: prdata = {25'd0, key_len_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q   <= 1'b0;
      key_len_q   <= 7'd1;
      key_pos_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_e'(paddr[2]))
          REG_DECRYPT: decrypt_q <= pwdata[0];
          REG_KEY_LEN: key_len_q <= pwdata[6:0];
          default:     key_len_q <= key_len_q;
        endcase
      end
      key_pos_q   <= key_pos_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.char_out;
  assign m_axis_tuser_o  = out_q.invalid;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(key_pos_q) < DepthL)
    else $error("key position beyond key store depth");

  a_msg_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_acc |=> s1_valid_q)
    else $error("message item lost before cipher stage");

  a_key_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_acc |=> !s1_valid_q)
    else $error("key write item entered cipher stage");

  a_first_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (msg_acc && in_first) |=> (key_pos_q == '0) || (key_pos_q == PW'(1)))
    else $error("key position not restarted on first character");

  a_valid_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.invalid) |-> (sym_index(out_q.char_out) != BAD_INDEX))
    else $error("valid result outside the alphabet");
`endif

endmodule
